@@ hw/rtl/ssva_pkg.sv @@
// ---------------------------------------------------------------------------
// ssva_pkg
// Shared constants and the PAL note period table for the score sequencer.
// ---------------------------------------------------------------------------
package ssva_pkg;

  // Voice count default
  localparam int VOICES_DEF = 3;

  // Note period table geometry
  localparam int ROM_DEPTH = 64;
  localparam int ROM_AW    = 6;
  localparam int PERIOD_W  = 16;

  // Reset value of the waveform register
  localparam logic [7:0] WAVE_RESET = 8'd64;

  // PAL period for one note index
  function automatic logic [PERIOD_W-1:0] note_period(input logic [ROM_AW-1:0] idx);
    logic [PERIOD_W-1:0] p;
    unique case (idx)
      6'd0:  p = 16'd278;   6'd1:  p = 16'd295;   6'd2:  p = 16'd313;
      6'd3:  p = 16'd331;   6'd4:  p = 16'd351;   6'd5:  p = 16'd372;
      6'd6:  p = 16'd394;   6'd7:  p = 16'd417;   6'd8:  p = 16'd442;
      6'd9:  p = 16'd468;   6'd10: p = 16'd496;   6'd11: p = 16'd526;
      6'd12: p = 16'd557;   6'd13: p = 16'd590;   6'd14: p = 16'd625;
      6'd15: p = 16'd662;   6'd16: p = 16'd702;   6'd17: p = 16'd743;
      6'd18: p = 16'd788;   6'd19: p = 16'd834;   6'd20: p = 16'd884;
      6'd21: p = 16'd937;   6'd22: p = 16'd992;   6'd23: p = 16'd1051;
      6'd24: p = 16'd1114;  6'd25: p = 16'd1180;  6'd26: p = 16'd1250;
      6'd27: p = 16'd1325;  6'd28: p = 16'd1403;  6'd29: p = 16'd1487;
      6'd30: p = 16'd1575;  6'd31: p = 16'd1669;  6'd32: p = 16'd1768;
      6'd33: p = 16'd1873;  6'd34: p = 16'd1985;  6'd35: p = 16'd2103;
      6'd36: p = 16'd2228;  6'd37: p = 16'd2360;  6'd38: p = 16'd2500;
      6'd39: p = 16'd2649;  6'd40: p = 16'd2807;  6'd41: p = 16'd2973;
      6'd42: p = 16'd3150;  6'd43: p = 16'd3338;  6'd44: p = 16'd3536;
      6'd45: p = 16'd3746;  6'd46: p = 16'd3969;  6'd47: p = 16'd4205;
      6'd48: p = 16'd4455;  6'd49: p = 16'd4720;  6'd50: p = 16'd5001;
      6'd51: p = 16'd5298;  6'd52: p = 16'd5613;  6'd53: p = 16'd5947;
      6'd54: p = 16'd6300;  6'd55: p = 16'd6675;  6'd56: p = 16'd7072;
      6'd57: p = 16'd7493;  6'd58: p = 16'd7938;  6'd59: p = 16'd8410;
      6'd60: p = 16'd8910;  6'd61: p = 16'd9440;  6'd62: p = 16'd10001;
      6'd63: p = 16'd10596;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/ssva_ram.sv @@
// ---------------------------------------------------------------------------
// ssva_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ssva_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/score_sequencer_voice_allocator.sv @@
// ---------------------------------------------------------------------------
// score_sequencer_voice_allocator
// Frame-driven score sequencer: counts wait frames, requests score bytes,
// starts notes on the first free voice with a period from a PAL table RAM.
// ---------------------------------------------------------------------------
//  channel | ports        | beat contents
//  --------+--------------+--------------------------------------------------
//  input   | in_t*        | tuser: command; tdata: score_byte
//  result  | out_t*       | tuser: kind; tdata: voice, period, wave_bits, remaining
//  config  | cfg_p*       | reg 0 at 0x0: wave_setting
//
//  One beat is taken per cycle unless the result channel stalls; each result passes
//  the middle stage (control update and period RAM read), then the output register.
//  After reset the period RAM is filled from the table, one entry a cycle:
//  in_tready stays low until the fill is done. Configuration is taken throughout.
//  A stalled result holds in the output register while one more beat waits
//  in the middle stage; after the fill, in_tready drops only when both are full and stalled.
// ---------------------------------------------------------------------------
module score_sequencer_voice_allocator #(
  parameter int VOICES = ssva_pkg::VOICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] score_byte
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [1:0] voice, [17:2] period, [25:18] wave_bits,
                                  // [31:26] remaining
  output logic [2:0]  out_tuser,  // [2:0] kind
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = ssva_pkg::ROM_AW;
  localparam int PW = ssva_pkg::PERIOD_W;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_IDLE  = 3'd0,
    K_FRAME = 3'd1,
    K_NEED  = 3'd2,
    K_NOTE  = 3'd3,
    K_DROP  = 3'd4,
    K_WAIT  = 3'd5,
    K_END   = 3'd6,
    K_IGN   = 3'd7
  } kind_t;

  localparam logic [7:0] END_BYTE = 8'hff;

  // -------------------------------------------------------------------------
  // Configuration register
  // -------------------------------------------------------------------------
  logic [7:0] wave_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= ssva_pkg::WAVE_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == 1'b0)) begin
      wave_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {24'd0, wave_r} : 32'd0;

  // -------------------------------------------------------------------------
  // Period RAM fill after reset
  // -------------------------------------------------------------------------
  logic [AW:0] fill_cnt_r;
  logic        filling;

  assign filling = !fill_cnt_r[AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
    end else if (filling) begin
      fill_cnt_r <= fill_cnt_r + 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Pipeline handshake
  // -------------------------------------------------------------------------
  logic s1_v_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv    = !out_tvalid || out_tready;
  assign in_tready = !filling && (!s1_v_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  logic [PW-1:0] rom_rdata;

  ssva_ram #(
    .WIDTH (PW),
    .DEPTH (ssva_pkg::ROM_DEPTH)
  ) u_period_ram (
    .clk   (clk),
    .we    (filling),
    .waddr (fill_cnt_r[AW-1:0]),
    .wdata (ssva_pkg::note_period(fill_cnt_r[AW-1:0])),
    .re    (in_acc),
    .raddr (in_tdata[AW-1:0]),
    .rdata (rom_rdata)
  );

  // -------------------------------------------------------------------------
  // Sequencer state update
  // -------------------------------------------------------------------------
  logic              playing_r, playing_nxt;
  logic              fetching_r, fetching_nxt;
  logic [5:0]        wait_r, wait_nxt;
  logic [VOICES-1:0] busy_r, busy_nxt;
  kind_t             kind_nxt;
  logic [VW-1:0]     free_idx;
  logic              free_found;
  cmd_t              cmd;

  assign cmd = cmd_t'(in_tuser);

  // Find the lowest free voice
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!busy_r[v]) begin
        free_idx   = VW'(v);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    playing_nxt  = playing_r;
    fetching_nxt = fetching_r;
    wait_nxt     = wait_r;
    busy_nxt     = busy_r;
    kind_nxt     = K_IGN;
    unique case (cmd)
      CMD_START: begin
        playing_nxt  = 1'b1;
        fetching_nxt = 1'b0;
        wait_nxt     = '0;
        kind_nxt     = K_IDLE;
      end
      CMD_TICK: begin
        priority if (!playing_r) begin
          kind_nxt = K_IDLE;
        end else if (fetching_r) begin
          kind_nxt = K_NEED;
        end else if (wait_r != '0) begin
          wait_nxt = wait_r - 1'b1;
          kind_nxt = K_FRAME;
        end else begin
          fetching_nxt = 1'b1;
          kind_nxt     = K_NEED;
        end
      end
      CMD_BYTE: begin
        if (fetching_r) begin
          priority if (!in_tdata[7]) begin
            // Note: take the first free voice or drop it
            if (free_found) begin
              busy_nxt[free_idx] = 1'b1;
              kind_nxt           = K_NOTE;
            end else begin
              kind_nxt = K_DROP;
            end
          end else if (in_tdata == END_BYTE) begin
            busy_nxt     = '0;
            playing_nxt  = 1'b0;
            fetching_nxt = 1'b0;
            wait_nxt     = '0;
            kind_nxt     = K_END;
          end else begin
            // Wait: a nonzero length ends the fetch and counts one frame
            busy_nxt = '0;
            kind_nxt = K_WAIT;
            if (in_tdata[5:0] != '0) begin
              fetching_nxt = 1'b0;
              wait_nxt     = in_tdata[5:0] - 1'b1;
            end else begin
              wait_nxt = '0;
            end
          end
        end
      end
      CMD_NONE: begin
        kind_nxt = K_IGN;
      end
      default: begin
        kind_nxt = K_IGN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r  <= 1'b0;
      fetching_r <= 1'b0;
      wait_r     <= '0;
      busy_r     <= '0;
    end else if (in_acc) begin
      playing_r  <= playing_nxt;
      fetching_r <= fetching_nxt;
      wait_r     <= wait_nxt;
      busy_r     <= busy_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Middle stage: result fields waiting on the RAM read
  // -------------------------------------------------------------------------
  kind_t         s1_kind_r;
  logic [VW-1:0] s1_voice_r;
  logic [7:0]    s1_wave_r;
  logic [5:0]    s1_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= kind_nxt;
      s1_voice_r <= free_idx;
      s1_wave_r  <= wave_r;
      s1_rem_r   <= wait_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  logic          out_v_r;
  kind_t         out_kind_r;
  logic [1:0]    out_voice_r;
  logic [PW-1:0] out_period_r;
  logic [7:0]    out_wave_r;
  logic [5:0]    out_rem_r;
  logic          s1_note;

  assign s1_note = (s1_kind_r == K_NOTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      out_kind_r   <= s1_kind_r;
      out_voice_r  <= s1_note ? 2'(s1_voice_r) : 2'd0;
      out_period_r <= s1_note ? rom_rdata : '0;
      out_wave_r   <= s1_note ? s1_wave_r : 8'd0;
      out_rem_r    <= s1_rem_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_rem_r, out_wave_r, out_period_r, out_voice_r};

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    filling |-> !in_tready)
    else $error("input beat accepted during period RAM fill");

  a_fetch_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    fetching_r |-> playing_r)
    else $error("fetching while playback is off");

  a_wait_frees_voices: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd == CMD_BYTE) && fetching_r && in_tdata[7]) |=> (busy_r == '0))
    else $error("voices not freed by wait or end byte");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != K_NOTE)) |-> (out_tdata[25:0] == 26'd0))
    else $error("note fields set on a non-note result");

endmodule
